[rtl/stipple_region_fill_2bpp_core_assert.svh]
// ----------------------------------------------------------------------------
// stipple_region_fill_2bpp_core_assert.svh
// assertion macros used by the port checker of the stipple fill core
// ----------------------------------------------------------------------------
`ifndef STIPPLE_REGION_FILL_2BPP_CORE_ASSERT_SVH
`define STIPPLE_REGION_FILL_2BPP_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define SRF2_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srf2 check failed");

// next-cycle implication, held off during reset
`define SRF2_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srf2 check failed");

`endif

[rtl/srf2_pkg.sv]
// ----------------------------------------------------------------------------
// srf2_pkg
// shared types, constants and helpers of the 2bpp stipple fill core
// ----------------------------------------------------------------------------
package srf2_pkg;

  // panel geometry
  localparam int PANEL_COLS   = 480;
  localparam int PANEL_ROWS   = 272;
  localparam int PIX_PER_BYTE = 4;
  localparam int STORE_BYTES  = (PANEL_ROWS * PANEL_COLS + PIX_PER_BYTE - 1) / PIX_PER_BYTE;
  localparam int ADDR_W       = $clog2(STORE_BYTES);

  // field widths
  localparam int FIELD_W      = 9;
  localparam int BYTE_ADDR_W  = 15;
  localparam int STEP_W       = 4;
  localparam int WALK_W       = FIELD_W + 1;
  localparam int IDX_W        = $clog2((2 ** WALK_W) * (PANEL_COLS + 1));

  // configuration port
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;
  localparam int REG_IDX_W    = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_STIPPLE_STEP = '0;
  localparam logic [STEP_W-1:0]    STEP_RESET       = STEP_W'(3);

  localparam logic [7:0] PIXEL_HIGH_BIT = 8'h02;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t                  opcode;
    logic [FIELD_W-1:0]       row_start;
    logic [FIELD_W-1:0]       col_start;
    logic [FIELD_W-1:0]       row_end;
    logic [FIELD_W-1:0]       col_end;
    logic [BYTE_ADDR_W-1:0]   byte_address;
    logic [7:0]               byte_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_value;
    opcode_t    done_opcode;
  } out_item_t;

  // high-bit mask of a pixel inside its byte, nibbles swapped
  function automatic logic [7:0] pixel_mask(input logic [1:0] pix);
    logic [2:0] sh;
    sh = {pix, 1'b0} ^ 3'd4;
    return PIXEL_HIGH_BIT << sh;
  endfunction

endpackage

[rtl/srf2_cfg_regs.sv]
// ----------------------------------------------------------------------------
// srf2_cfg_regs
// apb-style register file holding the stipple step
// ----------------------------------------------------------------------------
module srf2_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [srf2_pkg::PADDR_W-1:0]   paddr,
  input  logic [srf2_pkg::PDATA_W-1:0]   pwdata,
  output logic [srf2_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output logic [srf2_pkg::STEP_W-1:0]    stipple_step
);

  logic [srf2_pkg::STEP_W-1:0]    step_r;
  logic [srf2_pkg::STEP_W-1:0]    step_nxt;
  logic [srf2_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_beat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[srf2_pkg::PADDR_W-1:2];
  assign wr_beat = psel && penable && pwrite && pready;

  // register write decode
  always_comb begin
    step_nxt = step_r;
    if (wr_beat && reg_idx == srf2_pkg::REG_STIPPLE_STEP) begin
      step_nxt = pwdata[srf2_pkg::STEP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= srf2_pkg::STEP_RESET;
    end else begin
      step_r <= step_nxt;
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (reg_idx == srf2_pkg::REG_STIPPLE_STEP) begin
      prdata = srf2_pkg::PDATA_W'(step_r);
    end
  end

  assign stipple_step = step_r;

endmodule

[rtl/stipple_region_fill_2bpp_core.sv]
// A byte write passes S_BYTE_WR and S_FINISH, a byte read S_RD_REQ, S_RD_WAIT
// and S_FINISH; a fill does one read-modify-write of the single-port frame
// store per pixel (S_FILL_RD, S_FILL_WR), one S_FILL_RD step per row change.
// One command at a time, the next taken in the cycle after the last leaves for
// the output register. After reset a clearing pass zeroes all 32640 bytes of the
// frame store while in_stall is high; apb writes still work.
// ----------------------------------------------------------------------------
// stipple_region_fill_2bpp_core
// 2bpp frame store with stippled region set/clear and byte write/read
// ----------------------------------------------------------------------------
module stipple_region_fill_2bpp_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  srf2_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output srf2_pkg::out_item_t            out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [srf2_pkg::PADDR_W-1:0]   paddr,
  input  logic [srf2_pkg::PDATA_W-1:0]   pwdata,
  output logic [srf2_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int ADDR_W = srf2_pkg::ADDR_W;
  localparam int WALK_W = srf2_pkg::WALK_W;
  localparam int IDX_W  = srf2_pkg::IDX_W;
  localparam int STEP_W = srf2_pkg::STEP_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BYTE_WR,
    S_RD_REQ,
    S_RD_WAIT,
    S_FILL_RD,
    S_FILL_WR,
    S_FINISH
  } state_t;

  // configuration registers
  logic [STEP_W-1:0] stipple_step;

  srf2_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .stipple_step (stipple_step)
  );

  // frame store
  logic [7:0]        mem [srf2_pkg::STORE_BYTES];
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_q_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_addr];
    end
  end

  // control and payload registers
  state_t                          state_r, state_nxt;
  logic [ADDR_W-1:0]               clr_addr_r, clr_addr_nxt;
  srf2_pkg::opcode_t               op_r, op_nxt;
  logic [srf2_pkg::BYTE_ADDR_W-1:0] baddr_r, baddr_nxt;
  logic [7:0]                      bval_r, bval_nxt;
  logic [WALK_W-1:0]               row_end_r, row_end_nxt;
  logic [WALK_W-1:0]               col_end_r, col_end_nxt;
  logic [WALK_W-1:0]               col_start_r, col_start_nxt;
  logic [WALK_W-1:0]               walk_row_r, walk_row_nxt;
  logic [WALK_W-1:0]               walk_col_r, walk_col_nxt;
  logic [IDX_W-1:0]                row_base_r, row_base_nxt;
  logic [ADDR_W-1:0]               fill_addr_r, fill_addr_nxt;
  logic [1:0]                      pix_r, pix_nxt;
  logic [7:0]                      res_val_r, res_val_nxt;
  logic                            out_valid_r, out_valid_nxt;
  srf2_pkg::out_item_t             out_data_r, out_data_nxt;

  // walk arithmetic
  logic [STEP_W-1:0]               step_eff;
  logic [IDX_W-1:0]                row_stride;
  logic [IDX_W-1:0]                pix_idx;
  logic [IDX_W-3:0]                pix_byte;
  logic                            pix_in_store;
  logic                            baddr_in_store;
  logic [7:0]                      mask;

  assign step_eff       = (stipple_step == '0) ? STEP_W'(1) : stipple_step;
  assign row_stride     = IDX_W'(step_eff) * IDX_W'(srf2_pkg::PANEL_COLS);
  assign pix_idx        = row_base_r + IDX_W'(walk_col_r);
  assign pix_byte       = pix_idx[IDX_W-1:2];
  assign pix_in_store   = int'(pix_byte) < srf2_pkg::STORE_BYTES;
  assign baddr_in_store = int'(baddr_r) < srf2_pkg::STORE_BYTES;
  assign mask           = srf2_pkg::pixel_mask(pix_r);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next-state and datapath
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    op_nxt        = op_r;
    baddr_nxt     = baddr_r;
    bval_nxt      = bval_r;
    row_end_nxt   = row_end_r;
    col_end_nxt   = col_end_r;
    col_start_nxt = col_start_r;
    walk_row_nxt  = walk_row_r;
    walk_col_nxt  = walk_col_r;
    row_base_nxt  = row_base_r;
    fill_addr_nxt = fill_addr_r;
    pix_nxt       = pix_r;
    res_val_nxt   = res_val_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = fill_addr_r;
    mem_wdata     = '0;

    case (state_r)
      // zero the store one byte a cycle
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_addr     = clr_addr_r;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (int'(clr_addr_r) == srf2_pkg::STORE_BYTES - 1) begin
          state_nxt = S_IDLE;
        end
      end

      // take a command beat, clip the region
      S_IDLE: begin
        if (in_valid) begin
          op_nxt        = in_data.opcode;
          baddr_nxt     = in_data.byte_address;
          bval_nxt      = in_data.byte_value;
          res_val_nxt   = '0;
          walk_row_nxt  = WALK_W'(in_data.row_start);
          walk_col_nxt  = WALK_W'(in_data.col_start);
          col_start_nxt = WALK_W'(in_data.col_start);
          row_base_nxt  = IDX_W'(in_data.row_start) * IDX_W'(srf2_pkg::PANEL_COLS);
          row_end_nxt   = (int'(in_data.row_end) > srf2_pkg::PANEL_ROWS) ?
                          WALK_W'(srf2_pkg::PANEL_ROWS) : WALK_W'(in_data.row_end);
          col_end_nxt   = (int'(in_data.col_end) > srf2_pkg::PANEL_COLS) ?
                          WALK_W'(srf2_pkg::PANEL_COLS) : WALK_W'(in_data.col_end);
          case (in_data.opcode)
            srf2_pkg::OP_WRITE: state_nxt = S_BYTE_WR;
            srf2_pkg::OP_READ:  state_nxt = S_RD_REQ;
            default:            state_nxt = S_FILL_RD;
          endcase
        end
      end

      S_BYTE_WR: begin
        mem_we    = baddr_in_store;
        mem_addr  = baddr_r[ADDR_W-1:0];
        mem_wdata = bval_r;
        state_nxt = S_FINISH;
      end

      S_RD_REQ: begin
        mem_re    = baddr_in_store;
        mem_addr  = baddr_r[ADDR_W-1:0];
        state_nxt = S_RD_WAIT;
      end

      S_RD_WAIT: begin
        res_val_nxt = baddr_in_store ? mem_q_r : 8'h00;
        state_nxt   = S_FINISH;
      end

      // walk: end of region, next row, fetch the pixel's byte, or skip a pixel outside the store
      S_FILL_RD: begin
        if (walk_row_r >= row_end_r || col_start_r >= col_end_r) begin
          walk_row_nxt = '0;
          walk_col_nxt = '0;
          state_nxt    = S_FINISH;
        end else if (walk_col_r >= col_end_r) begin
          walk_row_nxt = walk_row_r + WALK_W'(step_eff);
          row_base_nxt = row_base_r + row_stride;
          walk_col_nxt = col_start_r;
        end else if (pix_in_store) begin
          mem_re        = 1'b1;
          mem_addr      = pix_byte[ADDR_W-1:0];
          fill_addr_nxt = pix_byte[ADDR_W-1:0];
          pix_nxt       = pix_idx[1:0];
          state_nxt     = S_FILL_WR;
        end else begin
          walk_col_nxt = walk_col_r + WALK_W'(step_eff);
        end
      end

      // modify the fetched byte and write it back
      S_FILL_WR: begin
        mem_we       = 1'b1;
        mem_addr     = fill_addr_r;
        mem_wdata    = (op_r == srf2_pkg::OP_SET) ? (mem_q_r | mask) : (mem_q_r & ~mask);
        walk_col_nxt = walk_col_r + WALK_W'(step_eff);
        state_nxt    = S_FILL_RD;
      end

      // hand the result to the output register once it is free
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.read_value  = res_val_r;
          out_data_nxt.done_opcode = op_r;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      walk_row_r  <= '0;
      walk_col_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      walk_row_r  <= walk_row_nxt;
      walk_col_r  <= walk_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    baddr_r     <= baddr_nxt;
    bval_r      <= bval_nxt;
    row_end_r   <= row_end_nxt;
    col_end_r   <= col_end_nxt;
    col_start_r <= col_start_nxt;
    row_base_r  <= row_base_nxt;
    fill_addr_r <= fill_addr_nxt;
    pix_r       <= pix_nxt;
    res_val_r   <= res_val_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

[rtl/srf2_port_chk.sv]
// ----------------------------------------------------------------------------
// srf2_port_chk
// port-level checks of the stipple fill core, bound to the top level
// ----------------------------------------------------------------------------
`include "stipple_region_fill_2bpp_core_assert.svh"

module srf2_port_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input srf2_pkg::out_item_t out_data,
  input logic                pready
);

  // a stalled result beat holds
  `SRF2_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // only a byte read carries data
  `SRF2_ASSERT_NOW(a_rd_zero, clk, rst_n, out_valid && out_data.done_opcode != srf2_pkg::OP_READ, out_data.read_value == 8'h00)

  // one command at a time: taking a beat closes the input
  `SRF2_ASSERT_NEXT(a_one_cmd, clk, rst_n, in_valid && !in_stall, in_stall)

  // the clearing pass keeps the input closed right after reset
  `SRF2_ASSERT_NOW(a_clear_stall, clk, rst_n, $rose(rst_n), in_stall && pready)

endmodule

bind stipple_region_fill_2bpp_core srf2_port_chk u_port_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .pready    (pready)
);
